// ===== rtl/jacd_pkg.sv =====
// shared constants, codes and controller/datapath structs for the joystick axis conditioner
// no dependencies; every other file imports this package
package jacd_pkg;

    localparam int AXIS_COUNT = 3;
    localparam int AXIS_SLOTS = 3;
    localparam int FRAC_BITS  = 15;

    localparam int RAW_W      = 16;
    localparam int AXIS_W     = 17;
    localparam int BTN_W      = 15;
    localparam int ZONE_W     = 16;
    localparam int AXES_W     = 2;
    localparam int AXIS_IDX_W = AXES_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // magnitude of a normalised or dead-zoned value, up to 1.0
    localparam int MAG_W  = FRAC_BITS + 1;
    // divider operand widths
    localparam int DVS_W  = RAW_W + 1;
    localparam int DVD_W  = (RAW_W > MAG_W) ? RAW_W + FRAC_BITS : MAG_W + FRAC_BITS;
    localparam int CNT_W  = $clog2(DVD_W);

    localparam int ONE           = 1 << FRAC_BITS;
    // zone below 0.999 means zone < ceil(0.999 * one)
    localparam int RESCALE_LIMIT = (999 * ONE + 999) / 1000;

    localparam logic [CFG_IDX_W-1:0] REG_ENABLE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_AXES   = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_ZONE   = CFG_IDX_W'(2);

    typedef logic signed [RAW_W-1:0] raw_t;
    typedef logic [AXIS_W-1:0]       axis_t;

    typedef struct packed {
        logic                  capture;
        logic                  norm_start;
        logic                  zone;
        logic                  rescale_start;
        logic                  store_plain;
        logic                  store_div;
        logic                  emit;
        logic [AXIS_IDX_W-1:0] axis;
    } dp_cmd_t;

    typedef struct packed {
        logic              enable;
        logic [AXES_W-1:0] axes_in_use;
        logic              rescale;
        logic              div_busy;
        logic              div_done;
        logic              out_free;
    } dp_status_t;

endpackage

// ===== rtl/jacd_if.sv =====
// valid/ready channel interfaces: sample input, conditioned result, register writes
// depends on jacd_pkg
interface jacd_in_if import jacd_pkg::*; ();
    logic             valid;
    logic             ready;
    raw_t             raw_x;
    raw_t             raw_y;
    raw_t             raw_z;
    logic [BTN_W-1:0] button_bits;

    modport source (output valid, output raw_x, output raw_y, output raw_z,
                    output button_bits, input ready);
    modport sink   (input valid, input raw_x, input raw_y, input raw_z,
                    input button_bits, output ready);
endinterface

interface jacd_out_if import jacd_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [AXIS_W-1:0] axis_x;
    logic signed [AXIS_W-1:0] axis_y;
    logic signed [AXIS_W-1:0] axis_z;
    logic [BTN_W-1:0]        buttons_out;

    modport source (output valid, output axis_x, output axis_y, output axis_z,
                    output buttons_out, input ready);
    modport sink   (input valid, input axis_x, input axis_y, input axis_z,
                    input buttons_out, output ready);
endinterface

interface jacd_cfg_if import jacd_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/joystick_axis_autocal_deadzone.sv =====
// joystick axis conditioner: autocalibrating extremes, normalise, dead zone, rescale
// per axis in use: normalise division, dead zone, then a rescale division if the zone is
// below 0.999; other axes are skipped; a new sample is taken after the output register loads
// throughput: one sample at a time; the shared divider runs once or twice per axis in use
// reset (async, active low): enable on, three axes, zone 0, extremes -1 / +1, channels empty
// depends on jacd_pkg, jacd_if, jacd_ctrl, jacd_datapath
module joystick_axis_autocal_deadzone
    import jacd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    jacd_in_if.sink     sample,
    jacd_out_if.source  result,
    jacd_cfg_if.sink    cfg
);

    dp_cmd_t    cmd;
    dp_status_t status;
    logic       in_ready;
    logic       cfg_ready;
    logic       out_valid;
    axis_t      out_axis_x;
    axis_t      out_axis_y;
    axis_t      out_axis_z;
    logic [BTN_W-1:0] out_buttons;

    jacd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (sample.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    jacd_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .raw_x       (sample.raw_x),
        .raw_y       (sample.raw_y),
        .raw_z       (sample.raw_z),
        .button_bits (sample.button_bits),
        .cfg_valid   (cfg.valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg.index),
        .cfg_data    (cfg.data),
        .out_valid   (out_valid),
        .out_ready   (result.ready),
        .out_axis_x  (out_axis_x),
        .out_axis_y  (out_axis_y),
        .out_axis_z  (out_axis_z),
        .out_buttons (out_buttons)
    );

    assign sample.ready       = in_ready;
    assign cfg.ready          = cfg_ready;
    assign result.valid       = out_valid;
    assign result.axis_x      = out_axis_x;
    assign result.axis_y      = out_axis_y;
    assign result.axis_z      = out_axis_z;
    assign result.buttons_out = out_buttons;

    // one sample in flight: no back-to-back input transactions
    assert property (@(posedge clk) disable iff (!rst_n)
        (sample.valid && sample.ready) |=> !sample.ready)
        else $error("input taken while a sample is in flight");

    // the shared divider is never restarted mid-division
    assert property (@(posedge clk) disable iff (!rst_n)
        status.div_busy |-> !(cmd.norm_start || cmd.rescale_start))
        else $error("divider restarted while busy");

    // conditioned axes stay within -1.0 .. 1.0
    assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> ($signed(result.axis_x) >= -ONE && $signed(result.axis_x) <= ONE
                       && $signed(result.axis_y) >= -ONE && $signed(result.axis_y) <= ONE
                       && $signed(result.axis_z) >= -ONE && $signed(result.axis_z) <= ONE))
        else $error("conditioned axis out of range");

endmodule

// ===== rtl/jacd_divider.sv =====
// shared unsigned restoring divider, one quotient bit per cycle
// depends on jacd_pkg
module jacd_divider
    import jacd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             busy,
    output logic             done,
    output logic [DVD_W-1:0] quotient
);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DVS_W-1:0] rem_reg;
    logic [DVD_W-1:0] quo_reg;
    logic [DVS_W-1:0] dvs_reg;

    logic [DVS_W:0]   trial;
    logic [DVS_W:0]   diff;
    logic             fits;

    always_comb
    begin
        trial = {rem_reg, quo_reg[DVD_W-1]};
        diff  = trial - {1'b0, dvs_reg};
        fits  = trial >= {1'b0, dvs_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DVD_W - 1);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    // dividend shifts out of the top while quotient bits shift in at the bottom
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
            quo_reg <= {quo_reg[DVD_W-2:0], fits};
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== rtl/jacd_datapath.sv =====
// datapath: config registers, running extremes, normalise / dead zone / rescale, result register
// depends on jacd_pkg and jacd_divider
module jacd_datapath
    import jacd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  dp_cmd_t               cmd,
    output dp_status_t            status,
    input  raw_t                  raw_x,
    input  raw_t                  raw_y,
    input  raw_t                  raw_z,
    input  logic [BTN_W-1:0]      button_bits,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output axis_t                 out_axis_x,
    output axis_t                 out_axis_y,
    output axis_t                 out_axis_z,
    output logic [BTN_W-1:0]      out_buttons
);

    logic              enable_reg;
    logic [AXES_W-1:0] axes_reg;
    logic [ZONE_W-1:0] zone_reg;

    raw_t              raw_reg     [AXIS_SLOTS];
    logic [BTN_W-1:0]  btn_reg;
    raw_t              lowest_reg  [AXIS_SLOTS];
    raw_t              highest_reg [AXIS_SLOTS];
    logic              sign_reg;
    logic [MAG_W-1:0]  vmag_reg;
    logic [MAG_W-1:0]  vmag_next;
    axis_t             res_reg     [AXIS_SLOTS];

    logic              out_valid_reg;
    axis_t             out_x_reg;
    axis_t             out_y_reg;
    axis_t             out_z_reg;
    logic [BTN_W-1:0]  out_btn_reg;

    raw_t              x;
    raw_t              lo_new;
    raw_t              hi_new;
    logic [RAW_W:0]    sum;
    logic [RAW_W:0]    span;
    logic [RAW_W+1:0]  num;
    logic [RAW_W+1:0]  num_abs;
    logic              num_neg;

    logic [DVD_W-1:0]  div_dividend;
    logic [DVS_W-1:0]  div_divisor;
    logic              div_busy;
    logic              div_done;
    logic [DVD_W-1:0]  quotient;

    logic [DVD_W-1:0]  zone_ext;
    logic [DVD_W-1:0]  zone_diff;
    axis_t             plain_mag;
    axis_t             div_mag;
    axis_t             plain_val;
    axis_t             div_val;

    always_comb
    begin
        x       = raw_reg[cmd.axis];
        lo_new  = (x < lowest_reg[cmd.axis])  ? x : lowest_reg[cmd.axis];
        hi_new  = (x > highest_reg[cmd.axis]) ? x : highest_reg[cmd.axis];
        sum     = {lo_new[RAW_W-1], lo_new} + {hi_new[RAW_W-1], hi_new};
        span    = {hi_new[RAW_W-1], hi_new} - {lo_new[RAW_W-1], lo_new};
        // 2x - (max + min), never larger in magnitude than the span
        num     = {x[RAW_W-1], x, 1'b0} - {sum[RAW_W], sum};
        num_neg = num[RAW_W+1];
        num_abs = num_neg ? (~num + 1'b1) : num;

        if (cmd.norm_start)
        begin
            div_dividend = DVD_W'({num_abs[RAW_W-1:0], {FRAC_BITS{1'b0}}});
            div_divisor  = DVS_W'(span);
        end
        else
        begin
            div_dividend = DVD_W'({vmag_reg, {FRAC_BITS{1'b0}}});
            div_divisor  = DVS_W'(ONE) - DVS_W'(zone_reg);
        end

        zone_ext  = DVD_W'(zone_reg);
        zone_diff = quotient - zone_ext;
        vmag_next = (quotient <= zone_ext) ? '0 : zone_diff[MAG_W-1:0];

        plain_mag = AXIS_W'(vmag_reg);
        div_mag   = AXIS_W'(quotient);
        plain_val = sign_reg ? (~plain_mag + 1'b1) : plain_mag;
        div_val   = sign_reg ? (~div_mag + 1'b1) : div_mag;
    end

    jacd_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.norm_start | cmd.rescale_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (quotient)
    );

    // configuration and running extremes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b1;
            axes_reg   <= AXES_W'(3);
            zone_reg   <= '0;
            for (int i = 0; i < AXIS_SLOTS; i++)
            begin
                lowest_reg[i]  <= '1;
                highest_reg[i] <= RAW_W'(1);
            end
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_ENABLE: enable_reg <= cfg_data[0];
                    REG_AXES:   axes_reg   <= cfg_data[AXES_W-1:0];
                    REG_ZONE:   zone_reg   <= cfg_data[ZONE_W-1:0];
                    default:    ;
                endcase
            end
            if (cmd.norm_start)
            begin
                lowest_reg[cmd.axis]  <= lo_new;
                highest_reg[cmd.axis] <= hi_new;
            end
        end
    end

    // working registers of the item in flight
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            raw_reg[0] <= raw_x;
            raw_reg[1] <= raw_y;
            raw_reg[2] <= raw_z;
            btn_reg    <= button_bits;
            for (int i = 0; i < AXIS_SLOTS; i++)
            begin
                res_reg[i] <= '0;
            end
        end
        if (cmd.norm_start)
        begin
            sign_reg <= num_neg;
        end
        if (cmd.zone)
        begin
            vmag_reg <= vmag_next;
        end
        if (cmd.store_plain)
        begin
            res_reg[cmd.axis] <= plain_val;
        end
        if (cmd.store_div)
        begin
            res_reg[cmd.axis] <= div_val;
        end
    end

    // result register, free to load again once its transaction completes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_x_reg   <= res_reg[0];
            out_y_reg   <= res_reg[1];
            out_z_reg   <= res_reg[2];
            out_btn_reg <= enable_reg ? btn_reg : '0;
        end
    end

    assign cfg_ready   = 1'b1;
    assign out_valid   = out_valid_reg;
    assign out_axis_x  = out_x_reg;
    assign out_axis_y  = out_y_reg;
    assign out_axis_z  = out_z_reg;
    assign out_buttons = out_btn_reg;

    assign status.enable      = enable_reg;
    assign status.axes_in_use = axes_reg;
    assign status.rescale     = zone_reg < ZONE_W'(RESCALE_LIMIT);
    assign status.div_busy    = div_busy;
    assign status.div_done    = div_done;
    assign status.out_free    = !out_valid_reg || out_ready;

endmodule

// ===== rtl/jacd_ctrl.sv =====
// controller: walks the axes of one sample and sequences the shared divider
// depends on jacd_pkg
module jacd_ctrl
    import jacd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_NORM = 3'd1;
    localparam logic [2:0] S_DIV1 = 3'd2;
    localparam logic [2:0] S_ZONE = 3'd3;
    localparam logic [2:0] S_DIV2 = 3'd4;
    localparam logic [2:0] S_EMIT = 3'd5;

    logic [2:0]            state_reg;
    logic [2:0]            state_next;
    logic [AXIS_IDX_W-1:0] axis_reg;
    logic [AXIS_IDX_W-1:0] axis_next;
    logic                  last_axis;
    logic                  in_use;
    logic [2:0]            after_axis;

    always_comb
    begin
        last_axis  = axis_reg == AXIS_IDX_W'(AXIS_COUNT - 1);
        in_use     = status.enable && (axis_reg < status.axes_in_use);
        after_axis = last_axis ? S_EMIT : S_NORM;

        cmd        = '0;
        cmd.axis   = axis_reg;
        state_next = state_reg;
        axis_next  = axis_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    axis_next   = '0;
                    state_next  = S_NORM;
                end
            end
            S_NORM:
            begin
                if (in_use)
                begin
                    cmd.norm_start = 1'b1;
                    state_next     = S_DIV1;
                end
                else
                begin
                    state_next = after_axis;
                    if (!last_axis)
                    begin
                        axis_next = axis_reg + 1'b1;
                    end
                end
            end
            S_DIV1:
            begin
                if (status.div_done)
                begin
                    cmd.zone   = 1'b1;
                    state_next = S_ZONE;
                end
            end
            S_ZONE:
            begin
                if (status.rescale)
                begin
                    cmd.rescale_start = 1'b1;
                    state_next        = S_DIV2;
                end
                else
                begin
                    cmd.store_plain = 1'b1;
                    state_next      = after_axis;
                    if (!last_axis)
                    begin
                        axis_next = axis_reg + 1'b1;
                    end
                end
            end
            S_DIV2:
            begin
                if (status.div_done)
                begin
                    cmd.store_div = 1'b1;
                    state_next    = after_axis;
                    if (!last_axis)
                    begin
                        axis_next = axis_reg + 1'b1;
                    end
                end
            end
            S_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            axis_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            axis_reg  <= axis_next;
        end
    end

    assign in_ready = state_reg == S_IDLE;

endmodule

// ===== sim/tb_joystick_axis_autocal_deadzone.sv =====
// self-checking testbench for joystick_axis_autocal_deadzone: directed and random samples,
// checked against an in-bench predictor of extremes, normalisation, dead zone and rescale
// depends on jacd_pkg, jacd_if and the rtl top level
module tb_joystick_axis_autocal_deadzone;
    import jacd_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE = CFG_IDX_W'(3);
    localparam int QUIET_LIMIT     = 4000;
    localparam int SETTLE_CYCLES   = 250;
    localparam int TRAFFIC_PHASES  = 12;
    localparam int ITEMS_PER_PHASE = 125;
    localparam int ZONE_ANY        = -1;
    localparam int BUTTON_MAX      = (1 << BTN_W) - 1;
    localparam int BUSY_PCT        = 77;
    localparam int MIXED_PCT       = 29;

    typedef struct {
        axis_t            ax;
        axis_t            ay;
        axis_t            az;
        logic [BTN_W-1:0] buttons;
    } conditioned_t;

    typedef struct {
        logic              en;
        logic [AXES_W-1:0] axes;
        int                zone;
        int                amp;
    } traffic_phase_t;

    logic clk;
    logic rst_n;

    jacd_in_if  sample_ch ();
    jacd_out_if result_ch ();
    jacd_cfg_if cfg_ch ();

    joystick_axis_autocal_deadzone dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    // predictor state
    logic               enable_reg;
    logic [AXES_W-1:0]  axes_reg;
    logic [ZONE_W-1:0]  zone_reg;
    longint             axis_low [AXIS_SLOTS];
    longint             axis_high [AXIS_SLOTS];

    conditioned_t pending_results [$];
    conditioned_t head;
    int           errors = 0;
    int           idle_pct;
    int           stall_pct;
    int unsigned  quiet_cycles = 0;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic axis_t condition_reading(int a, raw_t reading);
        longint one_q;
        longint x;
        longint num;
        longint n;
        longint d;
        longint v;
        longint mag;
        one_q = longint'(1) << FRAC_BITS;
        x = reading;
        if (x < axis_low[a])
            axis_low[a] = x;
        if (x > axis_high[a])
            axis_high[a] = x;
        num = 2 * x - (axis_high[a] + axis_low[a]);
        n = (num * one_q) / (axis_high[a] - axis_low[a]);
        d = zone_reg;
        mag = (n < 0) ? -n : n;
        if (mag <= d)
            v = 0;
        else if (n > 0)
            v = n - d;
        else
            v = n + d;
        // rescale only while the zone is below 0.999
        if (1000 * d < 999 * one_q)
            v = (v * one_q) / (one_q - d);
        return v[AXIS_W-1:0];
    endfunction

    function automatic conditioned_t predict_conditioned(raw_t rx, raw_t ry, raw_t rz,
                                                         logic [BTN_W-1:0] btn);
        conditioned_t r;
        raw_t         reading [AXIS_SLOTS];
        axis_t        v [AXIS_SLOTS];
        int           a;
        reading[0] = rx;
        reading[1] = ry;
        reading[2] = rz;
        for (a = 0; a < AXIS_SLOTS; a++)
            v[a] = '0;
        r.buttons = '0;
        if (enable_reg)
        begin
            r.buttons = btn;
            for (a = 0; a < AXIS_SLOTS && a < AXIS_COUNT; a++)
            begin
                if (a < axes_reg)
                    v[a] = condition_reading(a, reading[a]);
            end
        end
        r.ax = v[0];
        r.ay = v[1];
        r.az = v[2];
        return r;
    endfunction

    function automatic void check_field(string field, logic [AXIS_W-1:0] want,
                                        logic [AXIS_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
            errors++;
        end
    endfunction

    function automatic raw_t random_reading(int amp);
        int pick;
        pick = $urandom_range(9);
        if (pick == 0)
            return raw_t'(-amp);
        if (pick == 1)
            return raw_t'(amp - 1);
        return raw_t'(int'($urandom_range(2 * amp - 1)) - amp);
    endfunction

    // amplitudes grow over the phases that update the extremes, so the extremes widen gradually
    function automatic traffic_phase_t traffic_phase(int p);
        traffic_phase_t t;
        case (p)
            0:       t = '{1'b1, 2'd3, 0, 8};
            1:       t = '{1'b1, 2'd3, ZONE_ANY, 8};
            2:       t = '{1'b1, 2'd2, 512, 64};
            3:       t = '{1'b1, 2'd1, ZONE_ANY, 256};
            4:       t = '{1'b1, 2'd3, 32735, 256};
            5:       t = '{1'b1, 2'd3, 32736, 1024};
            6:       t = '{1'b0, 2'd3, 100, 32768};
            7:       t = '{1'b1, 2'd0, 0, 32768};
            8:       t = '{1'b1, 2'd3, 32768, 2048};
            9:       t = '{1'b1, 2'd3, 65535, 4096};
            10:      t = '{1'b1, 2'd3, ZONE_ANY, 16384};
            default: t = '{1'b1, 2'd3, 0, 32768};
        endcase
        return t;
    endfunction

    // expects to be called at a falling edge and returns at one with valid still high
    task automatic send_reading(raw_t rx, raw_t ry, raw_t rz, logic [BTN_W-1:0] btn);
        conditioned_t expected;
        while ($urandom_range(99) < idle_pct)
        begin
            sample_ch.valid = 1'b0;
            @(negedge clk);
        end
        sample_ch.valid       = 1'b1;
        sample_ch.raw_x       = rx;
        sample_ch.raw_y       = ry;
        sample_ch.raw_z       = rz;
        sample_ch.button_bits = btn;
        @(posedge clk);
        while (!sample_ch.ready)
            @(posedge clk);
        expected = predict_conditioned(rx, ry, rz, btn);
        pending_results.insert(pending_results.size(), expected);
        @(negedge clk);
    endtask

    task automatic wait_for_results();
        sample_ch.valid = 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic reg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        wait_for_results();
        cfg_ch.valid = 1'b1;
        cfg_ch.index = idx;
        cfg_ch.data  = value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        case (idx)
            REG_ENABLE: enable_reg = value[0];
            REG_AXES:   axes_reg   = value[AXES_W-1:0];
            REG_ZONE:   zone_reg   = value[ZONE_W-1:0];
            default:    ;
        endcase
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    task automatic test_reset_defaults();
        send_reading(0, 0, 0, '0);
        send_reading(1, -1, 0, 15'h7fff);
        send_reading(-1, 1, 1, 15'h5555);
    endtask

    task automatic test_disable();
        reg_write(REG_ENABLE, 0);
        send_reading(32767, -32768, 12345, 15'h2aaa);
        reg_write(REG_ENABLE, 1);
        // extremes must be untouched by the disabled sample
        send_reading(1, 1, 1, 15'h1234);
    endtask

    task automatic test_axes_in_use();
        reg_write(REG_AXES, 0);
        send_reading(100, -100, 50, 15'h0f0f);
        reg_write(REG_AXES, 1);
        send_reading(-32768, 5, 5, 15'h7000);
        send_reading(32767, 5, 5, 15'h000f);
        reg_write(REG_AXES, 2);
        send_reading(0, 3, 7, 15'h0001);
        reg_write(REG_AXES, 3);
    endtask

    task automatic test_dead_zone();
        reg_write(REG_ZONE, 1);
        send_reading(0, 0, 0, 15'h0100);
        send_reading(16384, 2, -2, 15'h0200);
        reg_write(REG_ZONE, 16384);
        send_reading(8000, 1, -1, 15'h0400);
        send_reading(-30000, 0, 0, 15'h0800);
        // largest zone that is still rescaled, then the smallest that is not
        reg_write(REG_ZONE, 32735);
        send_reading(32767, 0, 0, 15'h1000);
        send_reading(-32000, 4, -4, 15'h2000);
        reg_write(REG_ZONE, 32736);
        send_reading(32767, 0, 0, 15'h4000);
        reg_write(REG_ZONE, 32768);
        send_reading(32767, -5, 5, 15'h3c3c);
        reg_write(REG_ZONE, 16'hffff);
        send_reading(-32768, 6, -6, 15'h4321);
        reg_write(REG_ZONE, 0);
    endtask

    task automatic test_spare_register();
        reg_write(REG_SPARE, 16'hffff);
        send_reading(-7, 3, -3, 15'h6789);
    endtask

    task automatic test_random_traffic();
        traffic_phase_t t;
        int             p;
        int             i;
        for (p = 0; p < TRAFFIC_PHASES; p++)
        begin
            t = traffic_phase(p);
            reg_write(REG_ENABLE, CFG_DATA_W'(t.en));
            reg_write(REG_AXES, CFG_DATA_W'(t.axes));
            reg_write(REG_ZONE,
                      CFG_DATA_W'((t.zone == ZONE_ANY) ? $urandom_range(32767) : t.zone));
            case (p % 4)
                0:
                begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    idle_pct  = BUSY_PCT;
                    stall_pct = 0;
                end
                2:
                begin
                    idle_pct  = 0;
                    stall_pct = BUSY_PCT;
                end
                default:
                begin
                    idle_pct  = MIXED_PCT;
                    stall_pct = MIXED_PCT;
                end
            endcase
            for (i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                // in odd phases, hold the sender off mid-phase until every result is back
                if (i == ITEMS_PER_PHASE / 2 && p % 2 == 1)
                    wait_for_results();
                send_reading(random_reading(t.amp), random_reading(t.amp),
                             random_reading(t.amp), BTN_W'($urandom_range(BUTTON_MAX)));
            end
        end
    endtask

    // receiver side: random stalls, changed at the falling edge
    initial
    begin
        result_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            result_ch.ready = ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (result_ch.valid && result_ch.ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: result with nothing pending, expected none, actual %h %h %h %h",
                         $time, result_ch.axis_x, result_ch.axis_y, result_ch.axis_z,
                         result_ch.buttons_out);
                errors++;
            end
            else
            begin
                head = pending_results.pop_front();
                check_field("axis_x", head.ax, result_ch.axis_x);
                check_field("axis_y", head.ay, result_ch.axis_y);
                check_field("axis_z", head.az, result_ch.axis_z);
                check_field("buttons_out", AXIS_W'(head.buttons), AXIS_W'(result_ch.buttons_out));
            end
        end
    end

    // watchdog: any transaction on any channel counts as progress
    always @(posedge clk)
    begin
        if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("joystick_axis_autocal_deadzone test failed");
            $finish;
        end
    end

    initial
    begin
        rst_n                 = 1'b0;
        idle_pct              = 0;
        stall_pct             = 0;
        sample_ch.valid       = 1'b0;
        sample_ch.raw_x       = '0;
        sample_ch.raw_y       = '0;
        sample_ch.raw_z       = '0;
        sample_ch.button_bits = '0;
        cfg_ch.valid          = 1'b0;
        cfg_ch.index          = '0;
        cfg_ch.data           = '0;
        enable_reg            = 1'b1;
        axes_reg              = 2'd3;
        zone_reg              = '0;
        for (int a = 0; a < AXIS_SLOTS; a++)
        begin
            axis_low[a]  = -1;
            axis_high[a] = 1;
        end
        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        test_reset_defaults();
        test_disable();
        test_axes_in_use();
        test_dead_zone();
        test_spare_register();
        test_random_traffic();

        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("joystick_axis_autocal_deadzone test passed");
        else
            $display("joystick_axis_autocal_deadzone test failed");
        $finish;
    end

endmodule
